// ===== sv/efcc_pkg.sv =====
`timescale 1ns / 1ps

package efcc_pkg;

  // Counter, frame length and output widths
  localparam int CntW = 32;
  localparam int LenW = 32;
  localparam int OutW = 32;

  // Header constants
  localparam logic [15:0] EtypeArp   = 16'h0806;
  localparam logic [15:0] EtypeIp    = 16'h0800;
  localparam logic [7:0]  ProtoIcmp  = 8'd1;
  localparam logic [7:0]  ProtoUdp   = 8'd17;
  localparam logic [7:0]  ProtoTcp   = 8'd6;
  localparam logic [7:0]  AllOnes    = 8'hFF;

  // Frame byte offsets
  localparam logic [LenW-1:0] PrefixLast = LenW'(3);
  localparam logic [LenW-1:0] MacBytes   = LenW'(6);
  localparam logic [LenW-1:0] EtypeHiPos = LenW'(12);
  localparam logic [LenW-1:0] EtypeLoPos = LenW'(13);
  localparam logic [LenW-1:0] EtypeBytes = LenW'(14);
  localparam logic [LenW-1:0] ProtoPos   = LenW'(23);

  // Counter slots, in output order
  localparam int NumCnt      = 9;
  localparam int CntFrames   = 0;
  localparam int CntBcast    = 1;
  localparam int CntArp      = 2;
  localparam int CntIp       = 3;
  localparam int CntUdp      = 4;
  localparam int CntTcp      = 5;
  localparam int CntIcmp     = 6;
  localparam int CntOtherIp  = 7;
  localparam int CntOther    = 8;

  typedef enum logic [2:0] {
    CLS_OTHER    = 3'd0,
    CLS_ARP      = 3'd1,
    CLS_ICMP     = 3'd2,
    CLS_UDP      = 3'd3,
    CLS_TCP      = 3'd4,
    CLS_OTHER_IP = 3'd5
  } cls_e;

  // Frame-done event from parser to statistics
  typedef struct packed {
    logic valid;
    cls_e cls;
    logic bcast;
  } frame_ev_t;

endpackage

// ===== sv/efcc_parser.sv =====
`timescale 1ns / 1ps

module efcc_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                slot_free_i,
  output efcc_pkg::frame_ev_t ev_o
);
  import efcc_pkg::*;

  // input register
  logic       valid_q;
  logic [7:0] byte_q;

  // frame state
  logic            in_prefix_q, in_prefix_d;
  logic [LenW-1:0] pos_q, pos_d;
  logic [LenW-1:0] len_q, len_d;
  logic [15:0]     etype_q, etype_d;
  logic            bcast_q, bcast_d;
  logic [7:0]      proto_q, proto_d;
  logic            seen_q, seen_d;

  logic            ends;
  logic            consume;
  logic [LenW-1:0] len_acc;
  logic [LenW-1:0] pos_inc;
  logic            et_ok;
  cls_e            cls;
  logic            bc_out;

  assign pos_inc = pos_q + LenW'(1);
  assign len_acc = (pos_q == '0) ? LenW'(byte_q) : {len_q[LenW-9:0], byte_q};

  always_comb begin
    in_prefix_d = in_prefix_q;
    pos_d       = pos_q;
    len_d       = len_q;
    etype_d     = etype_q;
    bcast_d     = bcast_q;
    proto_d     = proto_q;
    seen_d      = seen_q;
    ends        = 1'b0;
    cls         = CLS_OTHER;
    bc_out      = 1'b0;
    et_ok       = 1'b0;

    if (in_prefix_q) begin
      len_d = len_acc;
      if (pos_q == PrefixLast) begin
        in_prefix_d = 1'b0;
        pos_d       = '0;
        etype_d     = '0;
        bcast_d     = 1'b1;
        proto_d     = '0;
        seen_d      = 1'b0;
        // empty frame closes right on the last length byte
        if (len_acc == '0) begin
          ends        = 1'b1;
          in_prefix_d = 1'b1;
        end
      end else begin
        pos_d = pos_inc;
      end
    end else begin
      if (pos_q < MacBytes && byte_q != AllOnes) begin
        bcast_d = 1'b0;
      end
      if (pos_q == EtypeHiPos) begin
        etype_d = {byte_q, etype_q[7:0]};
      end else if (pos_q == EtypeLoPos) begin
        etype_d = {etype_q[15:8], byte_q};
      end else if (pos_q == ProtoPos) begin
        proto_d = byte_q;
        seen_d  = 1'b1;
      end
      pos_d = pos_inc;
      if (pos_inc >= len_q) begin
        ends        = 1'b1;
        in_prefix_d = 1'b1;
        pos_d       = '0;
        bc_out      = bcast_d && (len_q >= MacBytes);
        et_ok       = len_q >= EtypeBytes;
        if (et_ok && etype_d == EtypeArp) begin
          cls = CLS_ARP;
        end else if (et_ok && etype_d == EtypeIp) begin
          if (seen_d && proto_d == ProtoIcmp) begin
            cls = CLS_ICMP;
          end else if (seen_d && proto_d == ProtoUdp) begin
            cls = CLS_UDP;
          end else if (seen_d && proto_d == ProtoTcp) begin
            cls = CLS_TCP;
          end else begin
            cls = CLS_OTHER_IP;
          end
        end
      end
    end
  end

  // a frame-ending byte waits for a free result slot
  assign consume    = valid_q && (!ends || slot_free_i);
  assign in_ready_o = !valid_q || consume;

  assign ev_o.valid = valid_q && ends && slot_free_i;
  assign ev_o.cls   = cls;
  assign ev_o.bcast = bc_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (consume) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_prefix_q <= 1'b1;
      pos_q       <= '0;
      len_q       <= '0;
      etype_q     <= '0;
      bcast_q     <= 1'b1;
      proto_q     <= '0;
      seen_q      <= 1'b0;
    end else if (consume) begin
      in_prefix_q <= in_prefix_d;
      pos_q       <= pos_d;
      len_q       <= len_d;
      etype_q     <= etype_d;
      bcast_q     <= bcast_d;
      proto_q     <= proto_d;
      seen_q      <= seen_d;
    end
  end

endmodule

// ===== sv/efcc_stats.sv =====
`timescale 1ns / 1ps

module efcc_stats (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  efcc_pkg::frame_ev_t ev_i,
  output logic                slot_free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          frame_class_o,
  output logic                is_broadcast_o,
  output logic [31:0]         frames_total_o,
  output logic [31:0]         broadcast_total_o,
  output logic [31:0]         arp_total_o,
  output logic [31:0]         ip_total_o,
  output logic [31:0]         udp_total_o,
  output logic [31:0]         tcp_total_o,
  output logic [31:0]         icmp_total_o,
  output logic [31:0]         other_ip_total_o,
  output logic [31:0]         other_total_o
);
  import efcc_pkg::*;

  logic [CntW-1:0] cnt_q [NumCnt];
  logic [CntW-1:0] cnt_d [NumCnt];
  logic            out_valid_q;
  cls_e            cls_q;
  logic            bcast_q;
  logic            is_ip;

  assign slot_free_o = !out_valid_q || out_ready_i;
  assign is_ip = ev_i.cls == CLS_ICMP || ev_i.cls == CLS_UDP ||
                 ev_i.cls == CLS_TCP || ev_i.cls == CLS_OTHER_IP;

  always_comb begin
    for (int k = 0; k < NumCnt; k++) begin
      cnt_d[k] = cnt_q[k];
    end
    if (ev_i.valid) begin
      cnt_d[CntFrames] = cnt_q[CntFrames] + CntW'(1);
      if (ev_i.bcast) begin
        cnt_d[CntBcast] = cnt_q[CntBcast] + CntW'(1);
      end
      if (is_ip) begin
        cnt_d[CntIp] = cnt_q[CntIp] + CntW'(1);
      end
      case (ev_i.cls)
        CLS_ARP:      cnt_d[CntArp]     = cnt_q[CntArp] + CntW'(1);
        CLS_ICMP:     cnt_d[CntIcmp]    = cnt_q[CntIcmp] + CntW'(1);
        CLS_UDP:      cnt_d[CntUdp]     = cnt_q[CntUdp] + CntW'(1);
        CLS_TCP:      cnt_d[CntTcp]     = cnt_q[CntTcp] + CntW'(1);
        CLS_OTHER_IP: cnt_d[CntOtherIp] = cnt_q[CntOtherIp] + CntW'(1);
        default:      cnt_d[CntOther]   = cnt_q[CntOther] + CntW'(1);
      endcase
    end
  end

  // counters only move on a new result, so they double as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumCnt; k++) begin
        cnt_q[k] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      for (int k = 0; k < NumCnt; k++) begin
        cnt_q[k] <= cnt_d[k];
      end
      if (ev_i.valid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_i.valid) begin
      cls_q   <= ev_i.cls;
      bcast_q <= ev_i.bcast;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign frame_class_o     = cls_q;
  assign is_broadcast_o    = bcast_q;
  assign frames_total_o    = OutW'(cnt_q[CntFrames]);
  assign broadcast_total_o = OutW'(cnt_q[CntBcast]);
  assign arp_total_o       = OutW'(cnt_q[CntArp]);
  assign ip_total_o        = OutW'(cnt_q[CntIp]);
  assign udp_total_o       = OutW'(cnt_q[CntUdp]);
  assign tcp_total_o       = OutW'(cnt_q[CntTcp]);
  assign icmp_total_o      = OutW'(cnt_q[CntIcmp]);
  assign other_ip_total_o  = OutW'(cnt_q[CntOtherIp]);
  assign other_total_o     = OutW'(cnt_q[CntOther]);

endmodule

// ===== sv/ethernet_frame_classifier_counter_top.sv =====
`timescale 1ns / 1ps

// Channel  | Handshake                 | Payload
// ---------+---------------------------+--------------------------------------
// input    | in_valid_i / in_ready_o   | data_byte_i (length prefix, frame)
// result   | out_valid_o / out_ready_i | frame_class_o, is_broadcast_o, totals
//
// One byte per cycle is taken unless a frame-ending byte is held. A result is
// formed from a record's last byte: input register, parse/classify, counters.
// Reset clears the parser to expect a length prefix and zeroes all counters.
// While a result waits, bytes that do not end a frame keep flowing; only a
// frame-ending byte holds in the input register until the result is taken.
// Empty records (length zero) give a result on the last prefix byte.

module ethernet_frame_classifier_counter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  frame_class_o,
  output logic        is_broadcast_o,
  output logic [31:0] frames_total_o,
  output logic [31:0] broadcast_total_o,
  output logic [31:0] arp_total_o,
  output logic [31:0] ip_total_o,
  output logic [31:0] udp_total_o,
  output logic [31:0] tcp_total_o,
  output logic [31:0] icmp_total_o,
  output logic [31:0] other_ip_total_o,
  output logic [31:0] other_total_o
);
  import efcc_pkg::*;

  frame_ev_t ev;        // frame done, classified
  logic      slot_free; // result register can take a new request

  efcc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .slot_free_i (slot_free),
    .ev_o        (ev)
  );

  efcc_stats u_stats (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ev_i              (ev),
    .slot_free_o       (slot_free),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .frame_class_o     (frame_class_o),
    .is_broadcast_o    (is_broadcast_o),
    .frames_total_o    (frames_total_o),
    .broadcast_total_o (broadcast_total_o),
    .arp_total_o       (arp_total_o),
    .ip_total_o        (ip_total_o),
    .udp_total_o       (udp_total_o),
    .tcp_total_o       (tcp_total_o),
    .icmp_total_o      (icmp_total_o),
    .other_ip_total_o  (other_ip_total_o),
    .other_total_o     (other_total_o)
  );

  // Input only stalls behind a result that is not being taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled with free result slot");

  // Every finished frame bumps the frame total by exactly one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev.valid |=> (frames_total_o == $past(frames_total_o) + 32'd1))
    else $error("frame total did not advance");

  // Frame and IP totals hold when no frame finishes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ev.valid |=> ($stable(frames_total_o) && $stable(ip_total_o)))
    else $error("counter moved without a frame");

  // A UDP frame bumps both the UDP total and the IP total
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev.valid && ev.cls == CLS_UDP) |=> (ip_total_o == $past(ip_total_o) + 32'd1
      && udp_total_o == $past(udp_total_o) + 32'd1))
    else $error("UDP frame not counted as IP");

endmodule
